FILE: sv/bmcc_pkg.sv
package bmcc_pkg;

	localparam int TICK_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int IVL_WIDTH = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;
	localparam int ADDR_WIDTH = 4;
	localparam int DATA_WIDTH = 32;

	localparam logic [CFG_WIDTH-1:0] INIT_TICKS_RST = CFG_WIDTH'(5);
	localparam logic [CFG_WIDTH-1:0] HOLD_TICKS_RST = CFG_WIDTH'(100);
	localparam logic [CFG_WIDTH-1:0] PASS_TICKS_RST = CFG_WIDTH'(30);

	typedef enum logic [1:0] {
		REG_INIT_TICKS = 2'd0,
		REG_HOLD_TICKS = 2'd1,
		REG_PASS_TICKS = 2'd2,
		REG_DEBOUNCE   = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE         = 5'd0,
		ST_INIT_1       = 5'd1,
		ST_DOWN_1       = 5'd2,
		ST_HOLD_1       = 5'd3,
		ST_HOLD_ON_1    = 5'd4,
		ST_PASS_1       = 5'd5,
		ST_INIT_2       = 5'd6,
		ST_DOWN_2       = 5'd7,
		ST_HOLD_2       = 5'd8,
		ST_HOLD_ON_2    = 5'd9,
		ST_PASS_2       = 5'd10,
		ST_INIT_3       = 5'd11,
		ST_DOWN_3       = 5'd12,
		ST_HOLD_3       = 5'd13,
		ST_HOLD_ON_3    = 5'd14,
		ST_PASS_3       = 5'd15,
		ST_SINGLE       = 5'd16,
		ST_DOUBLE       = 5'd17,
		ST_TRIPLE       = 5'd18,
		ST_HOLD_ON_PASS = 5'd19,
		ST_INIT_UP_1    = 5'd20,
		ST_INIT_UP_2    = 5'd21,
		ST_INIT_UP_3    = 5'd22
	} phase_t;

	typedef enum logic [1:0] {
		ARM_NONE,
		ARM_INIT,
		ARM_HOLD,
		ARM_PASS
	} arm_t;

endpackage

FILE: sv/button_multi_click_classifier.sv
// Multi-click button classifier.
// The input channel (in_valid/in_ready, pressed) carries one sampled button
// level per tick. Each accepted item advances the classifier by one tick and
// produces exactly one result item on the output channel (out_valid/out_ready,
// status_code, held_ticks): the state after that tick and the ticks since the
// last press start, saturating at 65535.
// The result of an item accepted at an edge is valid right after that edge.
// Throughput is one item per cycle while results are taken; the state update and
// the timeout compare sit between the state registers and the output register.
// When the receiver stalls, the result is held in the output register and the
// input accepts a new item only in the cycle in which the held result is taken.
// Configuration goes through the APB port: init_ticks at 0x0, hold_ticks_limit
// at 0x4, pass_ticks at 0x8, release_debounce_enable at 0xC. A new value is used
// the next time a timeout is armed. The user makes writes while the block
// is idle; the block does not enforce this. Reset puts the classifier in idle
// with counters cleared, registers at 5, 100, 30 and 0, and no result pending.
module button_multi_click_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bmcc_pkg::ADDR_WIDTH-1:0]    paddr,
	input  logic [bmcc_pkg::DATA_WIDTH-1:0]    pwdata,
	output logic [bmcc_pkg::DATA_WIDTH-1:0]    prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               pressed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [4:0]                         status_code,
	output logic [15:0]                        held_ticks
);

	localparam int TW = bmcc_pkg::TICK_WIDTH;
	localparam int IW = bmcc_pkg::IVL_WIDTH;
	localparam int CW = bmcc_pkg::CFG_WIDTH;
	localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

	logic [CW-1:0] init_ticks_q;
	logic [CW-1:0] hold_ticks_q;
	logic [CW-1:0] pass_ticks_q;
	logic          debounce_q;

	bmcc_pkg::phase_t phase_q;
	bmcc_pkg::phase_t phase_n;
	bmcc_pkg::arm_t   arm_sel;
	logic             clr_hold;
	logic [TW-1:0]    tmo_elapsed_q;
	logic [IW-1:0]    tmo_interval_q;
	logic [TW-1:0]    hold_elapsed_q;
	logic [TW-1:0]    tmo_inc;
	logic [TW-1:0]    hold_inc;
	logic [TW-1:0]    hold_n;
	logic             expired;
	logic             in_acc;
	logic             wr_en;
	logic [1:0]       reg_sel;
	logic [32:0]      hold_ext;

	logic [4:0]       status_s1;
	logic [15:0]      held_s1;
	logic             valid_s1;

	// configuration port
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ticks_q <= bmcc_pkg::INIT_TICKS_RST;
			hold_ticks_q <= bmcc_pkg::HOLD_TICKS_RST;
			pass_ticks_q <= bmcc_pkg::PASS_TICKS_RST;
			debounce_q   <= 1'b0;
		end else if (wr_en) begin
			case (bmcc_pkg::reg_idx_t'(reg_sel))
				bmcc_pkg::REG_INIT_TICKS: init_ticks_q <= pwdata[CW-1:0];
				bmcc_pkg::REG_HOLD_TICKS: hold_ticks_q <= pwdata[CW-1:0];
				bmcc_pkg::REG_PASS_TICKS: pass_ticks_q <= pwdata[CW-1:0];
				bmcc_pkg::REG_DEBOUNCE:   debounce_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (bmcc_pkg::reg_idx_t'(reg_sel))
			bmcc_pkg::REG_INIT_TICKS: prdata = bmcc_pkg::DATA_WIDTH'(init_ticks_q);
			bmcc_pkg::REG_HOLD_TICKS: prdata = bmcc_pkg::DATA_WIDTH'(hold_ticks_q);
			bmcc_pkg::REG_PASS_TICKS: prdata = bmcc_pkg::DATA_WIDTH'(pass_ticks_q);
			bmcc_pkg::REG_DEBOUNCE:   prdata = bmcc_pkg::DATA_WIDTH'(debounce_q);
			default:                  prdata = '0;
		endcase
	end

	// handshake
	assign in_ready = !valid_s1 || out_ready;
	assign in_acc   = in_valid && in_ready;

	// counters advance first, saturating
	assign tmo_inc  = (tmo_elapsed_q == TICK_MAX) ? tmo_elapsed_q : tmo_elapsed_q + TW'(1);
	assign hold_inc = (hold_elapsed_q == TICK_MAX) ? hold_elapsed_q : hold_elapsed_q + TW'(1);
	assign expired  = IW'(tmo_inc) >= tmo_interval_q;

	// next state
	always_comb begin
		phase_n  = phase_q;
		arm_sel  = bmcc_pkg::ARM_NONE;
		clr_hold = 1'b0;
		case (phase_q)
			bmcc_pkg::ST_IDLE: begin
				if (pressed) begin
					phase_n  = bmcc_pkg::ST_INIT_1;
					arm_sel  = bmcc_pkg::ARM_INIT;
					clr_hold = 1'b1;
				end
			end
			bmcc_pkg::ST_INIT_1, bmcc_pkg::ST_INIT_2, bmcc_pkg::ST_INIT_3,
			bmcc_pkg::ST_HOLD_1, bmcc_pkg::ST_HOLD_2, bmcc_pkg::ST_HOLD_3: begin
				if (pressed) begin
					if (expired)
						phase_n = bmcc_pkg::phase_t'(phase_q + 5'd1);
				end else if (phase_q inside {bmcc_pkg::ST_INIT_1, bmcc_pkg::ST_INIT_2,
						bmcc_pkg::ST_INIT_3}) begin
					phase_n = bmcc_pkg::ST_IDLE;
				end else if (debounce_q) begin
					arm_sel = bmcc_pkg::ARM_INIT;
					case (phase_q)
						bmcc_pkg::ST_HOLD_1: phase_n = bmcc_pkg::ST_INIT_UP_1;
						bmcc_pkg::ST_HOLD_2: phase_n = bmcc_pkg::ST_INIT_UP_2;
						default:             phase_n = bmcc_pkg::ST_INIT_UP_3;
					endcase
				end else begin
					arm_sel = bmcc_pkg::ARM_PASS;
					phase_n = bmcc_pkg::phase_t'(phase_q + 5'd2);
				end
			end
			bmcc_pkg::ST_DOWN_1, bmcc_pkg::ST_DOWN_2, bmcc_pkg::ST_DOWN_3: begin
				if (pressed) begin
					phase_n = bmcc_pkg::phase_t'(phase_q + 5'd1);
					arm_sel = bmcc_pkg::ARM_HOLD;
				end else begin
					phase_n = bmcc_pkg::ST_IDLE;
				end
			end
			bmcc_pkg::ST_HOLD_ON_1, bmcc_pkg::ST_HOLD_ON_2, bmcc_pkg::ST_HOLD_ON_3: begin
				if (!pressed)
					phase_n = bmcc_pkg::ST_HOLD_ON_PASS;
			end
			bmcc_pkg::ST_PASS_1, bmcc_pkg::ST_PASS_2: begin
				if (pressed) begin
					phase_n  = bmcc_pkg::phase_t'(phase_q + 5'd1);
					arm_sel  = bmcc_pkg::ARM_INIT;
					clr_hold = 1'b1;
				end else if (expired) begin
					phase_n = (phase_q == bmcc_pkg::ST_PASS_1) ? bmcc_pkg::ST_SINGLE
						: bmcc_pkg::ST_DOUBLE;
				end
			end
			bmcc_pkg::ST_PASS_3: begin
				if (!pressed && expired)
					phase_n = bmcc_pkg::ST_TRIPLE;
			end
			bmcc_pkg::ST_INIT_UP_1, bmcc_pkg::ST_INIT_UP_2, bmcc_pkg::ST_INIT_UP_3: begin
				if (pressed) begin
					case (phase_q)
						bmcc_pkg::ST_INIT_UP_1: phase_n = bmcc_pkg::ST_HOLD_1;
						bmcc_pkg::ST_INIT_UP_2: phase_n = bmcc_pkg::ST_HOLD_2;
						default:                phase_n = bmcc_pkg::ST_HOLD_3;
					endcase
				end else if (expired) begin
					arm_sel = bmcc_pkg::ARM_PASS;
					case (phase_q)
						bmcc_pkg::ST_INIT_UP_1: phase_n = bmcc_pkg::ST_PASS_1;
						bmcc_pkg::ST_INIT_UP_2: phase_n = bmcc_pkg::ST_PASS_2;
						default:                phase_n = bmcc_pkg::ST_PASS_3;
					endcase
				end
			end
			default: begin
				// result states and unused codes
				if (!pressed)
					phase_n = bmcc_pkg::ST_IDLE;
			end
		endcase
	end

	assign hold_n   = clr_hold ? '0 : hold_inc;
	assign hold_ext = 33'(hold_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= bmcc_pkg::ST_IDLE;
			tmo_elapsed_q  <= '0;
			tmo_interval_q <= '0;
			hold_elapsed_q <= '0;
		end else if (in_acc) begin
			phase_q        <= phase_n;
			hold_elapsed_q <= hold_n;
			case (arm_sel)
				bmcc_pkg::ARM_INIT: begin
					tmo_elapsed_q  <= '0;
					tmo_interval_q <= IW'(init_ticks_q);
				end
				bmcc_pkg::ARM_HOLD: begin
					tmo_elapsed_q  <= '0;
					tmo_interval_q <= IW'(hold_ticks_q);
				end
				bmcc_pkg::ARM_PASS: begin
					tmo_elapsed_q  <= '0;
					tmo_interval_q <= IW'(pass_ticks_q);
				end
				default: tmo_elapsed_q <= tmo_inc;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1 <= 5'(phase_n);
			held_s1   <= (hold_ext > 33'h0FFFF) ? 16'hFFFF : hold_ext[15:0];
		end
	end

	assign out_valid   = valid_s1;
	assign status_code = status_s1;
	assign held_ticks  = held_s1;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	a_press_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && pressed && phase_q == bmcc_pkg::ST_IDLE
		|=> held_ticks == 16'd0 && status_code == 5'(bmcc_pkg::ST_INIT_1))
		else $error("press from idle did not start a new press");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_code <= 5'(bmcc_pkg::ST_INIT_UP_3))
		else $error("status code out of range");

	a_timeout_armed: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && arm_sel != bmcc_pkg::ARM_NONE |=> tmo_elapsed_q == '0)
		else $error("timeout not cleared when armed");

endmodule
